### rtl/core/gmvp_pkg.sv
// gmvp_pkg: shared types, constants and mod-3 helpers for gf2_matvec_popcount_mod3
// no dependencies
package gmvp_pkg;

  localparam int unsigned KeyFields  = 4;
  localparam int unsigned WordWidth  = 64;
  localparam int unsigned CountWidth = 7;

  typedef logic [WordWidth-1:0]  word_t;
  typedef logic [CountWidth-1:0] count_t;
  typedef logic [1:0]            res_t;

  typedef struct packed {
    logic acc_en;
    logic clr;
    logic snap_en;
    logic res_en;
  } lane_ctrl_t;

  // count (0..64) modulo 3: even weights are 1, odd weights are 2 mod 3
  function automatic res_t mod3_of_count(count_t c);
    logic [3:0] s;
    s = 4'(c[0]) + 4'(c[2]) + 4'(c[4]) + 4'(c[6])
      + {3'(c[1]) + 3'(c[3]) + 3'(c[5]), 1'b0};
    if (s >= 4'd6) s = s - 4'd6;
    if (s >= 4'd3) s = s - 4'd3;
    return s[1:0];
  endfunction

  function automatic res_t add_mod3(res_t a, res_t b);
    logic [2:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= 3'd3) s = s - 3'd3;
    return s[1:0];
  endfunction

endpackage

### rtl/core/gmvp_lane.sv
// gmvp_lane: one 64-bit accumulator row word, its snapshot and its popcount residue
// depends on gmvp_pkg
module gmvp_lane (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  gmvp_pkg::lane_ctrl_t  ctrl_i,
  input  gmvp_pkg::word_t       key_word_i,
  output gmvp_pkg::res_t        res_o
);
  import gmvp_pkg::*;

  word_t acc_q, acc_d, acc_next;
  word_t snap_q;
  res_t  res_q;
  count_t cnt;

  assign acc_next = acc_q ^ (ctrl_i.acc_en ? key_word_i : '0);
  assign acc_d    = ctrl_i.clr ? '0 : acc_next;
  assign cnt      = CountWidth'($countones(snap_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.snap_en) begin
      snap_q <= acc_next;
    end
    if (ctrl_i.res_en) begin
      res_q <= mod3_of_count(cnt);
    end
  end

  assign res_o = res_q;

endmodule

### rtl/core/gmvp_merge.sv
// gmvp_merge: sums the lane residues modulo 3 into the output register
// depends on gmvp_pkg
module gmvp_merge #(
  parameter int unsigned ROW_WORDS = 4
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  output logic                      ready_o,
  input  logic [ROW_WORDS-1:0][1:0] lane_res_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output gmvp_pkg::res_t            residue_o
);
  import gmvp_pkg::*;

  logic out_valid_q, out_valid_d;
  res_t residue_q;
  res_t sum;

  always_comb begin
    sum = '0;
    for (int unsigned i = 0; i < ROW_WORDS; i++) begin
      sum = add_mod3(sum, lane_res_i[i]);
    end
  end

  assign ready_o = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (valid_i && ready_o) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      residue_q <= sum;
    end
  end

  assign out_valid_o = out_valid_q;
  assign residue_o   = residue_q;

endmodule

### rtl/core/gf2_matvec_popcount_mod3.sv
// gf2_matvec_popcount_mod3: top level, lane array plus merge stage
// depends on gmvp_pkg, gmvp_lane, gmvp_merge
//
//  channel | signals                                          | direction
//  in      | in_valid_i/in_ready_o, select_bit_i, key_word_*_i, | sink
//          | last_column_i                                     |
//  out     | out_valid_o/out_ready_i, residue_o                | source
//
// one column item per cycle unless a last item is stalled; each lane xors its key
// word into its row word when select_bit_i is set; an accepted last item's result
// goes through snapshot, lane popcount residue and merge into the output register
// reset clears the accumulator and all stage valids
// a stalled output only holds back the input when a last item finds all stages full
module gf2_matvec_popcount_mod3 #(
  parameter int unsigned ROW_WORDS = 4
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   select_bit_i,
  input  logic [63:0]            key_word_0_i,
  input  logic [63:0]            key_word_1_i,
  input  logic [63:0]            key_word_2_i,
  input  logic [63:0]            key_word_3_i,
  input  logic                   last_column_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [1:0]             residue_o
);
  import gmvp_pkg::*;

  word_t                     key_words [KeyFields];
  logic [ROW_WORDS-1:0][1:0] lane_res;
  lane_ctrl_t                ctrl;
  logic in_fire, s1_ready, s2_ready;
  logic s1_valid_q, s1_valid_d, s2_valid_q, s2_valid_d;

  assign key_words[0] = key_word_0_i;
  assign key_words[1] = key_word_1_i;
  assign key_words[2] = key_word_2_i;
  assign key_words[3] = key_word_3_i;

  assign s1_ready   = !s2_valid_q || s2_ready;
  assign in_ready_o = !s1_valid_q || s1_ready || !last_column_i;
  assign in_fire    = in_valid_i && in_ready_o;

  assign ctrl.acc_en  = in_fire && select_bit_i;
  assign ctrl.clr     = in_fire && last_column_i;
  assign ctrl.snap_en = in_fire && last_column_i;
  assign ctrl.res_en  = s1_valid_q && s1_ready;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (ctrl.snap_en) begin
      s1_valid_d = 1'b1;
    end else if (s1_ready) begin
      s1_valid_d = 1'b0;
    end
    s2_valid_d = s2_valid_q;
    if (ctrl.res_en) begin
      s2_valid_d = 1'b1;
    end else if (s2_ready) begin
      s2_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
    end
  end

  for (genvar g = 0; g < ROW_WORDS; g++) begin : g_lane
    word_t lane_key;
    if (g < KeyFields) begin : g_key
      assign lane_key = key_words[g];
    end else begin : g_nokey
      assign lane_key = '0;
    end
    gmvp_lane u_lane (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .key_word_i (lane_key),
      .res_o      (lane_res[g])
    );
  end

  gmvp_merge #(
    .ROW_WORDS (ROW_WORDS)
  ) u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (s2_valid_q),
    .ready_o     (s2_ready),
    .lane_res_i  (lane_res),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .residue_o   (residue_o)
  );

`ifndef SYNTHESIS
  // a last item never overwrites an unconsumed snapshot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.snap_en |-> (!s1_valid_q || s1_ready))
    else $error("snapshot overwritten");

  // a last item's snapshot is held in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.snap_en |=> s1_valid_q)
    else $error("snapshot valid lost");

  // lane residues move on only when the merge stage is free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid_q && !s2_ready) |=> (s2_valid_q && $stable(lane_res)))
    else $error("lane residues changed while stalled");

  // residue is always reduced
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (residue_o != 2'd3))
    else $error("residue not reduced");
`endif

endmodule

### tb/tb_top.sv
// tb_top: self-checking testbench for gf2_matvec_popcount_mod3, random and directed columns
// depends on gmvp_pkg and the gf2_matvec_popcount_mod3 rtl; predicts residues from a shadow
// accumulator and compares them in order against the output channel
`timescale 1ns / 100ps

module tb_top;
  import gmvp_pkg::*;

  localparam int unsigned NumItems   = 1100;
  localparam int unsigned CycleLimit = 200000;
  localparam word_t       AllOnes    = {WordWidth{1'b1}};

  class residue_scoreboard;
    word_t       row_acc[KeyFields];
    res_t        expected_q[$];
    int unsigned fails;

    function new();
      foreach (row_acc[i]) row_acc[i] = '0;
      fails = 0;
    endfunction

    function void note_column(logic sel, word_t w0, word_t w1, word_t w2, word_t w3,
                              logic last);
      int unsigned ones;
      if (sel) begin
        row_acc[0] ^= w0;
        row_acc[1] ^= w1;
        row_acc[2] ^= w2;
        row_acc[3] ^= w3;
      end
      if (last) begin
        ones = $countones({row_acc[3], row_acc[2], row_acc[1], row_acc[0]});
        expected_q.push_back(res_t'(ones % 3));
        foreach (row_acc[i]) row_acc[i] = '0;
      end
    endfunction

    task report_mismatch(string msg);
      $display("mismatch: %s", msg);
      fails++;
    endtask

    task check_residue(res_t got);
      res_t want;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("residue %0d with nothing pending", got));
      end else begin
        want = expected_q.pop_front();
        if (got !== want)
          report_mismatch($sformatf("residue got %0d expected %0d", got, want));
      end
    endtask
  endclass

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        in_valid_i    = 1'b0;
  logic        in_ready_o;
  logic        select_bit_i  = 1'b0;
  word_t       key_word_0_i  = '0;
  word_t       key_word_1_i  = '0;
  word_t       key_word_2_i  = '0;
  word_t       key_word_3_i  = '0;
  logic        last_column_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i   = 1'b0;
  logic [1:0]  residue_o;

  residue_scoreboard sb;
  int unsigned       cycle_count = 0;
  int unsigned       items_sent  = 0;
  int unsigned       burst_left  = 0;
  int unsigned       ready_mode  = 0;
  int unsigned       mode_left   = 0;
  int unsigned       mode_phase  = 0;

  gf2_matvec_popcount_mod3 dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .select_bit_i (select_bit_i),
    .key_word_0_i (key_word_0_i),
    .key_word_1_i (key_word_1_i),
    .key_word_2_i (key_word_2_i),
    .key_word_3_i (key_word_3_i),
    .last_column_i(last_column_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .residue_o    (residue_o)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CycleLimit);
    $display("tb: failure");
    $finish;
  end

  // receiver stall pattern
  always @(posedge clk_i) begin
    if (mode_left == 0) begin
      ready_mode = $urandom_range(0, 3);
      mode_left  = $urandom_range(20, 200);
    end
    mode_left--;
    mode_phase++;
    case (ready_mode)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= 1'($urandom_range(0, 1));
      2: out_ready_i <= ($urandom_range(0, 3) == 0);
      default: out_ready_i <= mode_phase[3];
    endcase
  end

  // output monitor, values are stable at the falling edge before the accepting edge
  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_residue(res_t'(residue_o));
  end

  function automatic word_t gen_word();
    case ($urandom_range(0, 9))
      0: return AllOnes;
      1: return '0;
      2: return word_t'(1) << $urandom_range(0, WordWidth - 1);
      3: return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // called at a rising edge, returns at the rising edge where the item is taken, or after an idle gap when a burst ends
  task automatic send_column(logic sel, word_t w0, word_t w1, word_t w2, word_t w3,
                             logic last);
    in_valid_i    <= 1'b1;
    select_bit_i  <= sel;
    key_word_0_i  <= w0;
    key_word_1_i  <= w1;
    key_word_2_i  <= w2;
    key_word_3_i  <= w3;
    last_column_i <= last;
    do @(negedge clk_i); while (!in_ready_o);
    @(posedge clk_i);
    sb.note_column(sel, w0, w1, w2, w3, last);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = $urandom_range(0, 1) ? $urandom_range(1, 6) : $urandom_range(20, 80);
    end
  endtask

  task automatic run_directed();
    word_t w;
    // single-column vectors
    send_column(1'b1, AllOnes, AllOnes, AllOnes, AllOnes, 1'b1);
    send_column(1'b0, AllOnes, AllOnes, AllOnes, AllOnes, 1'b1);
    send_column(1'b1, '0, '0, '0, '0, 1'b1);
    send_column(1'b1, 64'd3, '0, '0, '0, 1'b1);
    // same column twice cancels
    w = gen_word();
    send_column(1'b1, w, ~w, w, ~w, 1'b0);
    send_column(1'b1, w, ~w, w, ~w, 1'b1);
    // unselected last column leaves the sum alone
    send_column(1'b1, AllOnes, '0, '0, '0, 1'b0);
    send_column(1'b0, gen_word(), gen_word(), gen_word(), gen_word(), 1'b1);
    // one bit per word
    send_column(1'b1, 64'd1, 64'd2, 64'd4, 64'h8000_0000_0000_0000, 1'b1);
    // alternating patterns combine to all ones
    send_column(1'b1, {16{4'h5}}, {16{4'hA}}, {16{4'h5}}, {16{4'hA}}, 1'b0);
    send_column(1'b1, {16{4'hA}}, {16{4'h5}}, {16{4'hA}}, {16{4'h5}}, 1'b1);
    // 255 ones
    send_column(1'b1, AllOnes, AllOnes, AllOnes, ~word_t'(1), 1'b1);
    // a longer selected run
    for (int i = 0; i < 8; i++)
      send_column(1'b1, gen_word(), gen_word(), gen_word(), gen_word(), i == 7);
  endtask

  task automatic run_random();
    int unsigned len;
    int unsigned sel_mode;
    logic        sel;
    while (items_sent < NumItems) begin
      len      = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 48) : $urandom_range(1, 6);
      sel_mode = $urandom_range(0, 5);
      for (int unsigned i = 0; i < len; i++) begin
        case (sel_mode)
          0: sel = 1'b1;
          1: sel = 1'b0;
          default: sel = 1'($urandom_range(0, 1));
        endcase
        send_column(sel, gen_word(), gen_word(), gen_word(), gen_word(), i == len - 1);
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    run_random();
    in_valid_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.fails == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
